/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define DTM_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dtm_pkg.sv */
package dtm_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_LOAD_CUR  = 2'd0;
	localparam logic [1:0] CMD_LOAD_PREV = 2'd1;
	localparam logic [1:0] CMD_WEIGHT    = 2'd2;

	// Configuration register indexes.
	localparam int         CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 4'd1;

	localparam logic signed [15:0] ALPHA_RESET = 16'sd256;
	localparam logic signed [15:0] BETA_RESET  = 16'sd0;

	localparam logic signed [39:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] SUM_MIN = 40'sh80_0000_0000;
	localparam logic [8:0]         SKIP_MAX = 9'h1FF;
	localparam logic signed [57:0] ROUND_HALF = 58'sd128;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_FIN_A,
		ST_FIN_B,
		ST_FIN_C,
		ST_FIN_D,
		ST_EMIT
	} dtm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic capture;
		logic mul;
		logic acc;
		logic fin_a;
		logic fin_b;
		logic fin_c;
		logic fin_d;
		logic emit;
	} dtm_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_free;
		logic row_last;
	} dtm_stat_t;

endpackage

/* sv/dtm_if.sv */
interface dtm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [7:0]         elem_index;
	logic signed [15:0] elem_value;
	logic signed [31:0] prior_value;
	logic               row_last;

	modport source (output valid, cmd, elem_index, elem_value, prior_value, row_last,
		input ready);
	modport sink (input valid, cmd, elem_index, elem_value, prior_value, row_last,
		output ready);
endinterface

interface dtm_out_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] row_result;
	logic [8:0]         skip_count;

	modport source (output valid, row_result, skip_count, input ready);
	modport sink (input valid, row_result, skip_count, output ready);
endinterface

interface dtm_cfg_if;
	import dtm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/dtm_ram.sv */
module dtm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* sv/dtm_ctrl.sv */
`include "assert_macros.svh"

module dtm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic [1:0]         item_cmd,
	output logic               item_ready,
	input  dtm_pkg::dtm_stat_t stat,
	output dtm_pkg::dtm_ctrl_t ctl
);
	import dtm_pkg::*;

	dtm_state_t state_q;
	dtm_state_t state_d;
	logic       accept;

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && item_cmd == CMD_WEIGHT) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = stat.row_last ? ST_FIN_A : ST_IDLE;
			ST_FIN_A: state_d = ST_FIN_B;
			ST_FIN_B: state_d = ST_FIN_C;
			ST_FIN_C: state_d = ST_FIN_D;
			ST_FIN_D: state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl         = '0;
		item_ready  = 1'b0;
		case (state_q)
			ST_CLEAR: ctl.clear = 1'b1;
			ST_IDLE: begin
				item_ready  = 1'b1;
				ctl.load    = accept;
				ctl.capture = accept && item_cmd == CMD_WEIGHT;
			end
			ST_MUL:   ctl.mul   = 1'b1;
			ST_ACC:   ctl.acc   = 1'b1;
			ST_FIN_A: ctl.fin_a = 1'b1;
			ST_FIN_B: ctl.fin_b = 1'b1;
			ST_FIN_C: ctl.fin_c = 1'b1;
			ST_FIN_D: ctl.fin_d = 1'b1;
			ST_EMIT:  ctl.emit  = stat.out_free;
			default:  ctl       = '0;
		endcase
	end

	`DTM_ASSERT_NEXT(a_weight_starts_mul, clk, arst_n, accept && item_cmd == CMD_WEIGHT, state_q == ST_MUL, "weight beat did not start the multiply step")
	`DTM_ASSERT_NEXT(a_emit_waits, clk, arst_n, state_q == ST_EMIT && !stat.out_free, state_q == ST_EMIT, "left the emit step while the result register was full")
endmodule

/* sv/dtm_datapath.sv */
`include "assert_macros.svh"

module dtm_datapath #(
	parameter int VEC_LEN = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dtm_pkg::dtm_ctrl_t ctl,
	output dtm_pkg::dtm_stat_t stat,
	input  logic [1:0]         cmd,
	input  logic [7:0]         elem_index,
	input  logic signed [15:0] elem_value,
	input  logic signed [31:0] prior_value,
	input  logic               row_last,
	dtm_cfg_if.sink            cfg,
	dtm_out_if.source          result
);
	import dtm_pkg::*;

	localparam int AW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
	localparam int CW = $clog2(VEC_LEN + 1);

	logic signed [15:0] alpha_q;
	logic signed [15:0] beta_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      col_q;
	logic [8:0]         skips_q;
	logic signed [39:0] sum_q;
	logic               last_q;
	logic signed [15:0] weight_q;
	logic signed [31:0] prior_q;

	logic signed [31:0] prod_s1;
	logic               skip_s1;
	logic               ok_s1;

	logic signed [40:0] plo_q;
	logic signed [31:0] phi_q;
	logic signed [47:0] pb_q;
	logic signed [57:0] acc_q;

	logic               valid_q;
	logic signed [39:0] row_result_q;
	logic [8:0]         skip_count_q;

	logic [31:0]        idx_ext;
	logic               idx_ok;
	logic [AW-1:0]      idx_addr;
	logic               cur_we;
	logic               prev_we;
	logic [AW-1:0]      prev_waddr;
	logic [15:0]        prev_wdata;
	logic [15:0]        cur_rd;
	logic [15:0]        prev_rd;

	logic signed [15:0] cur;
	logic signed [15:0] prev;
	logic signed [16:0] diff;
	logic               near_zero;
	logic               reuse;
	logic signed [15:0] mul_op;
	logic               col_ok;
	logic [40:0]        sum_ext;
	logic signed [39:0] sum_sat;
	logic [49:0]        shifted;
	logic signed [39:0] res_sat;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			beta_q  <= BETA_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_ALPHA) begin
				alpha_q <= $signed(cfg.data);
			end
			if (cfg.index == REG_BETA) begin
				beta_q <= $signed(cfg.data);
			end
		end
	end

	// Vector stores.
	assign idx_ext  = 32'(elem_index);
	assign idx_ok   = idx_ext < 32'(VEC_LEN);
	assign idx_addr = idx_ext[AW-1:0];

	assign cur_we     = ctl.load && cmd == CMD_LOAD_CUR && idx_ok;
	assign prev_we    = ctl.clear || (ctl.load && cmd == CMD_LOAD_PREV && idx_ok);
	assign prev_waddr = ctl.clear ? clr_q : idx_addr;
	assign prev_wdata = ctl.clear ? 16'd0 : elem_value;

	dtm_ram #(.WIDTH(16), .DEPTH(VEC_LEN)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (idx_addr),
		.wdata (elem_value),
		.raddr (col_q[AW-1:0]),
		.rdata (cur_rd)
	);

	dtm_ram #(.WIDTH(16), .DEPTH(VEC_LEN)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (col_q[AW-1:0]),
		.rdata (prev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign stat.clear_last = clr_q == AW'(VEC_LEN - 1);

	// Weight capture.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			weight_q <= elem_value;
			prior_q  <= prior_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (ctl.capture) begin
			last_q <= row_last;
		end
	end

	assign stat.row_last = last_q;

	// Multiplier choice: reuse the previous element on a small nonzero change, unless |cur| is in 1..255.
	always_comb begin
		cur       = $signed(cur_rd);
		prev      = $signed(prev_rd);
		diff      = 17'(cur) - 17'(prev);
		near_zero = cur != 16'sd0 && cur > -16'sd256 && cur < 16'sd256;
		reuse     = !near_zero && diff != 17'sd0 && diff > -17'sd256 && diff < 17'sd256;
		mul_op    = reuse ? prev : cur;
		col_ok    = col_q < CW'(VEC_LEN);
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= weight_q * mul_op;
			skip_s1 <= reuse && col_ok;
			ok_s1   <= col_ok;
		end
	end

	// Saturating accumulate.
	always_comb begin
		sum_ext = {sum_q[39], sum_q} + {{9{prod_s1[31]}}, prod_s1};
		if (sum_ext[40] != sum_ext[39]) begin
			sum_sat = sum_ext[40] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = $signed(sum_ext[39:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			col_q   <= '0;
			skips_q <= '0;
		end else if (ctl.emit) begin
			sum_q   <= '0;
			col_q   <= '0;
			skips_q <= '0;
		end else if (ctl.acc && ok_s1) begin
			sum_q <= sum_sat;
			col_q <= col_q + CW'(1);
			if (skip_s1 && skips_q != SKIP_MAX) begin
				skips_q <= skips_q + 9'd1;
			end
		end
	end

	// Row result: the alpha product is split at bit 24 of the sum.
	always_ff @(posedge clk) begin
		if (ctl.fin_a) begin
			plo_q <= alpha_q * $signed({1'b0, sum_q[23:0]});
		end
		if (ctl.fin_b) begin
			phi_q <= alpha_q * $signed(sum_q[39:24]);
		end
		if (ctl.fin_c) begin
			pb_q <= beta_q * prior_q;
		end
		if (ctl.fin_d) begin
			acc_q <= (58'(phi_q) <<< 24) + 58'(plo_q) + (58'(pb_q) <<< 8) + ROUND_HALF;
		end
	end

	always_comb begin
		shifted = acc_q[57:8];
		if ((&shifted[49:39]) || !(|shifted[49:39])) begin
			res_sat = $signed(shifted[39:0]);
		end else begin
			res_sat = shifted[49] ? SUM_MIN : SUM_MAX;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			row_result_q <= res_sat;
			skip_count_q <= skips_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.emit) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign stat.out_free     = !valid_q || result.ready;
	assign result.valid      = valid_q;
	assign result.row_result = row_result_q;
	assign result.skip_count = skip_count_q;

	`DTM_ASSERT(a_skips_bounded, clk, arst_n, 1'b1, 32'(skips_q) <= 32'(col_q), "skips over columns")
	`DTM_ASSERT_NEXT(a_row_cleared, clk, arst_n, ctl.emit, {sum_q, col_q, skips_q} == '0, "row not cleared")
endmodule

/* sv/delta_threshold_matvec.sv */
// Load beats (current or previous element) are taken in the idle state and may follow back to back.
// A weight beat passes through capture, store read and multiply, then accumulate.
// A weight beat that ends a row then passes through four finishing steps and an emit step that
// loads the output register and waits while an earlier result is still held.
// After reset the previous-vector store is cleared entry by entry, during which no item is
// accepted; configuration writes are taken at all times and the gains reset to 1.0 and 0.0.

module delta_threshold_matvec #(
	parameter int VEC_LEN = 256
) (
	input logic       clk,
	input logic       arst_n,
	dtm_in_if.sink    item,
	dtm_out_if.source result,
	dtm_cfg_if.sink   cfg
);
	import dtm_pkg::*;

	// The controller sequences each weight beat through the shared datapath:
	// the store read is already under way when the beat is accepted, because
	// both stores are read at the current column at every clock. The next
	// cycle picks the multiplier (current or previous element), and the one
	// after adds the product into the saturating 40-bit row sum.
	//
	// At the end of a row, four further steps form the result. The alpha
	// product is built from two narrower multiplications, one for each half
	// of the row sum, and the beta product follows in a cycle of its own.
	// The three terms are then added with half an LSB for rounding. A last
	// emit step drops the extra eight fraction bits, saturates to 40 bits and
	// loads the output register, and waits there only if an earlier result
	// has not yet been taken.
	dtm_ctrl_t ctl;
	dtm_stat_t stat;

	dtm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_cmd   (item.cmd),
		.item_ready (item.ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	// The datapath holds both vector stores, the gain registers, the row
	// state and the output register; a loaded result stays until the sink
	// takes the beat, while the controller goes on to accept new beats.
	dtm_datapath #(.VEC_LEN(VEC_LEN)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cmd         (item.cmd),
		.elem_index  (item.elem_index),
		.elem_value  (item.elem_value),
		.prior_value (item.prior_value),
		.row_last    (item.row_last),
		.cfg         (cfg),
		.result      (result)
	);
endmodule

/* tb/sv/dtm_row_checker.sv */
// Watches all three channels of the delta matrix-vector block and predicts each row result.
module dtm_row_checker #(
	parameter int VEC_LEN = 256
) (
	input  logic clk,
	input  logic arst_n,
	dtm_in_if    item,
	dtm_out_if   result,
	dtm_cfg_if   cfg,
	output int   mismatches,
	output int   rows_in_flight,
	output int   rows_checked
);
	import dtm_pkg::*;

	localparam longint ROW_MAX = 64'sd549755813887;
	localparam longint ROW_MIN = -ROW_MAX - 64'sd1;

	typedef struct {
		logic signed [39:0] row_result;
		logic [8:0]         skip_count;
	} row_expect_t;

	logic signed [15:0] cur_vec [VEC_LEN];
	logic signed [15:0] prev_vec [VEC_LEN];
	logic signed [15:0] alpha;
	logic signed [15:0] beta;
	longint             row_acc;
	int                 col;
	int                 skips;
	row_expect_t        expected_rows [$];
	int                 fails;
	int                 done;

	assign mismatches   = fails;
	assign rows_checked = done;

	function automatic longint clamp40(longint v);
		if (v > ROW_MAX)
			return ROW_MAX;
		if (v < ROW_MIN)
			return ROW_MIN;
		return v;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: row %0d: %s", $time, done, what);
		fails++;
	endtask

	// One weight beat: pick the multiplier for this column, accumulate, and close the row
	// when the beat carries row_last.
	task automatic take_weight(logic signed [15:0] w, logic signed [31:0] prior, logic last);
		longint      cur;
		longint      prev;
		longint      factor;
		longint      d;
		longint      acc;
		row_expect_t e;
		if (col < VEC_LEN) begin
			cur    = cur_vec[col];
			prev   = prev_vec[col];
			factor = cur;
			if (cur == 0 || cur <= -256 || cur >= 256) begin
				d = cur - prev;
				if (d != 0 && d > -256 && d < 256) begin
					factor = prev;
					if (skips < SKIP_MAX)
						skips++;
				end
			end
			row_acc = clamp40(row_acc + longint'(w) * factor);
			col++;
		end
		if (last) begin
			acc = longint'(beta) * (longint'(prior) * 256) + longint'(alpha) * row_acc;
			e.row_result = 40'(clamp40((acc + 128) >>> 8));
			e.skip_count = 9'(skips);
			expected_rows.push_back(e);
			row_acc = 0;
			col     = 0;
			skips   = 0;
		end
	endtask

	task automatic check_row();
		row_expect_t e;
		if (expected_rows.size() == 0) begin
			report_mismatch("result beat with no row outstanding");
			return;
		end
		e = expected_rows.pop_front();
		if (result.row_result !== e.row_result)
			report_mismatch($sformatf("row_result %0d, expected %0d",
				result.row_result, e.row_result));
		if (result.skip_count !== e.skip_count)
			report_mismatch($sformatf("skip_count %0d, expected %0d",
				result.skip_count, e.skip_count));
		done++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VEC_LEN; k++) begin
				cur_vec[k]  = '0;
				prev_vec[k] = '0;
			end
			alpha   = ALPHA_RESET;
			beta    = BETA_RESET;
			row_acc = 0;
			col     = 0;
			skips   = 0;
			expected_rows.delete();
			rows_in_flight <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_ALPHA)
					alpha = cfg.data;
				else if (cfg.index == REG_BETA)
					beta = cfg.data;
			end
			if (result.valid && result.ready)
				check_row();
			if (item.valid && item.ready) begin
				case (item.cmd)
					CMD_LOAD_CUR: begin
						if (item.elem_index < VEC_LEN)
							cur_vec[item.elem_index] = item.elem_value;
					end
					CMD_LOAD_PREV: begin
						if (item.elem_index < VEC_LEN)
							prev_vec[item.elem_index] = item.elem_value;
					end
					CMD_WEIGHT: begin
						take_weight(item.elem_value, item.prior_value, item.row_last);
					end
					default: begin
					end
				endcase
			end
			rows_in_flight <= expected_rows.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// Top level of the delta matrix-vector testbench. It generates clock, reset and all stimulus,
// and gives the verdict; prediction and comparison live in the row checker beside the block.
module tb;
	import dtm_pkg::*;

	localparam int VEC_LEN = 256;
	// The block ignores command code 3 entirely.
	localparam logic [1:0] CMD_RESERVED = 2'd3;
	// An index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;
	// Cycles to let pass once no row is outstanding, so that any weight beat still in the
	// pipeline has finished before the gains change.
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 40;
	// Gain settings per phase, extremes first; the phase marked by RANDOM_PHASE uses random gains.
	localparam int ALPHA_SET [PHASES] = '{32767, -32768, -32768, 32767, 0, -1, 0, 256};
	localparam int BETA_SET [PHASES]  = '{32767, -32768, 32767, -32768, 256, 1, 0, 0};
	localparam int RANDOM_PHASE = 6;

	logic clk = 1'b0;
	logic arst_n;

	always #6 clk = ~clk;

	dtm_in_if  item_bus ();
	dtm_out_if row_bus ();
	dtm_cfg_if cfg_bus ();

	int mismatches;
	int rows_in_flight;
	int rows_checked;

	delta_threshold_matvec #(
		.VEC_LEN(VEC_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(row_bus),
		.cfg   (cfg_bus)
	);

	dtm_row_checker #(
		.VEC_LEN(VEC_LEN)
	) i_row_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_bus),
		.result        (row_bus),
		.cfg           (cfg_bus),
		.mismatches    (mismatches),
		.rows_in_flight(rows_in_flight),
		.rows_checked  (rows_checked)
	);

	// The stimulus keeps its own note of which current-vector entries have been written and of
	// the block's column position, so that no weight ever reads an entry that was never loaded.
	bit cur_loaded [VEC_LEN];
	int col_pos;
	int beats_sent;
	int burst_left;
	int settings_run;

	// Gaps before a beat: mostly none or short, a few long, and now and then a burst with no
	// gaps at all so that back-to-back beats are covered too.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(10, 60);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// A Q8.8 value, biased towards the edges of the delta rule: zero, plus and minus 1.0,
	// values below 1.0 in magnitude and the extremes of the range.
	function automatic logic signed [15:0] pick_q88();
		case ($urandom_range(0, 11))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return 16'sd256;
			4: return -16'sd256;
			5: return 16'(int'($urandom_range(0, 510)) - 255);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_prior();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'($urandom);
		endcase
	endfunction

	// Drives one beat and returns at the clock edge where it is accepted. The valid line is only
	// lowered when a gap is due, so back-to-back beats keep it high across the edge.
	task automatic send_beat(input logic [1:0] cmd, input logic [7:0] idx,
		input logic signed [15:0] val, input logic signed [31:0] prior, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.cmd         <= cmd;
		item_bus.elem_index  <= idx;
		item_bus.elem_value  <= val;
		item_bus.prior_value <= prior;
		item_bus.row_last    <= last;
		do @(posedge clk); while (!item_bus.ready);
		if (cmd == CMD_LOAD_CUR)
			cur_loaded[idx] = 1'b1;
		if (cmd == CMD_WEIGHT) begin
			if (last)
				col_pos = 0;
			else if (col_pos < VEC_LEN)
				col_pos++;
		end
		if (cmd != CMD_RESERVED)
			beats_sent++;
	endtask

	// A weight beat; if its column has never had a current element, one is loaded first.
	task automatic send_weight(input logic signed [15:0] w, input logic last);
		if (col_pos < VEC_LEN && !cur_loaded[col_pos])
			send_beat(CMD_LOAD_CUR, 8'(col_pos), pick_q88(), pick_prior(), 1'($urandom));
		send_beat(CMD_WEIGHT, 8'($urandom), w, pick_prior(), last);
	endtask

	// A well-formed row: optionally fresh current and previous elements for its columns, with
	// the previous element often placed just inside or just outside the 1.0 delta threshold,
	// then the weights with row_last on the final one.
	task automatic send_row(input int len, input bit preload);
		logic signed [15:0] c;
		int                 d;
		if (preload) begin
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) < 6) begin
					c = pick_q88();
					send_beat(CMD_LOAD_CUR, 8'(k), c, pick_prior(), 1'b0);
					if ($urandom_range(0, 1)) begin
						case ($urandom_range(0, 3))
							0: d = 0;
							1: d = $urandom_range(0, 1) ? 256 : -256;
							default: d = int'($urandom_range(0, 510)) - 255;
						endcase
						send_beat(CMD_LOAD_PREV, 8'(k), 16'(c - d), pick_prior(), 1'b0);
					end
				end
			end
		end
		for (int k = 0; k < len; k++)
			send_weight(pick_q88(), k == len - 1);
	endtask

	// Mostly well-formed rows of small size; some rows reuse whatever the stores hold, and the
	// rest is noise: reserved commands and stray loads, some with row_last set.
	task automatic run_random(input int n);
		int target;
		int r;
		int len;
		target = beats_sent + n;
		while (beats_sent < target) begin
			r = $urandom_range(0, 99);
			len = $urandom_range(0, 99);
			if (len < 80)
				len = $urandom_range(1, 8);
			else if (len < 96)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 120);
			if (r < 12) begin
				case ($urandom_range(0, 2))
					0: send_beat(CMD_RESERVED, 8'($urandom), 16'($urandom), 32'($urandom),
						1'($urandom));
					1: send_beat(CMD_LOAD_PREV, 8'($urandom), pick_q88(), pick_prior(),
						1'($urandom));
					default: send_beat(CMD_LOAD_CUR, 8'($urandom), pick_q88(), pick_prior(),
						1'($urandom));
				endcase
			end else if (r < 20) begin
				send_row(len, 1'b0);
			end else begin
				send_row(len, 1'b1);
			end
		end
	endtask

	// The sender holds off until every outstanding row has come back, then lets the pipeline
	// settle. Used before each gain change and at the end of the run.
	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (rows_in_flight != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// Receiver: the ready line runs in stretches of a mode: always ready, choppy with short
	// stalls, or choppy with the odd long stall.
	initial begin
		int hold;
		int mode;
		int mode_left;
		int r;
		row_bus.ready = 1'b0;
		hold = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold > 0) begin
				hold--;
				row_bus.ready <= 1'b0;
			end else if (mode == 0) begin
				row_bus.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (mode == 2 && r < 4) begin
					hold = $urandom_range(10, 40);
					row_bus.ready <= 1'b0;
				end else begin
					row_bus.ready <= (r >= 30);
				end
			end
		end
	end

	// Main stimulus.
	initial begin
		logic signed [15:0] a_gain;
		logic signed [15:0] b_gain;
		arst_n               = 1'b0;
		item_bus.valid       = 1'b0;
		item_bus.cmd         = CMD_LOAD_CUR;
		item_bus.elem_index  = '0;
		item_bus.elem_value  = '0;
		item_bus.prior_value = '0;
		item_bus.row_last    = 1'b0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = REG_ALPHA;
		cfg_bus.data         = '0;
		col_pos      = 0;
		beats_sent   = 0;
		burst_left   = 0;
		settings_run = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset gains of 1.0 and 0.0. The previous elements are set so that
		// columns 0, 1 and 4 reuse the previous element (a zero current element, and changes of
		// just under 1.0 at both ends of the range), column 2 has no change, column 3 changes by
		// exactly 1.0 and columns 5 to 7 hold current elements below 1.0 in magnitude.
		send_beat(CMD_LOAD_PREV, 8'd0, 16'sd50, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_PREV, 8'd1, 16'sd32512, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_PREV, 8'd2, 16'sh8000, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_PREV, 8'd4, -16'sd1, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd0, 16'sd0, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd1, 16'sh7FFF, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd2, 16'sh8000, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd3, 16'sd256, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd4, -16'sd256, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd5, 16'sd100, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd6, 16'sd255, 32'sd0, 1'b0);
		send_beat(CMD_LOAD_CUR, 8'd7, -16'sd255, 32'sd0, 1'b0);
		// A load that carries row_last must not close a row; a reserved command does nothing.
		send_beat(CMD_LOAD_PREV, 8'hFF, 16'sh8000, 32'sh7FFF_FFFF, 1'b1);
		send_beat(CMD_RESERVED, 8'hFF, 16'sh7FFF, 32'sh8000_0000, 1'b1);
		send_beat(CMD_WEIGHT, 8'h00, 16'sh7FFF, 32'sh8000_0000, 1'b0);
		send_beat(CMD_WEIGHT, 8'hFF, 16'sh8000, 32'sd0, 1'b0);
		send_beat(CMD_WEIGHT, 8'h55, 16'sh7FFF, 32'sd0, 1'b0);
		send_beat(CMD_WEIGHT, 8'hAA, 16'sh8000, 32'sd0, 1'b0);
		send_beat(CMD_WEIGHT, 8'h01, 16'sd1, 32'sd0, 1'b0);
		send_beat(CMD_WEIGHT, 8'h80, -16'sd1, 32'sd0, 1'b0);
		send_beat(CMD_WEIGHT, 8'h7F, 16'sd256, 32'sd0, 1'b0);
		send_beat(CMD_WEIGHT, 8'h00, -16'sd256, 32'sh7FFF_FFFF, 1'b1);
		// A row of a single column.
		send_beat(CMD_WEIGHT, 8'h00, 16'sh8000, 32'sh8000_0000, 1'b1);

		// Random phases, each at its own pair of gains. Changing gains is only done once every
		// outstanding row has returned.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			a_gain = 16'(ALPHA_SET[p]);
			b_gain = 16'(BETA_SET[p]);
			if (p == RANDOM_PHASE) begin
				a_gain = 16'($urandom);
				b_gain = 16'($urandom);
			end
			cfg_beat(REG_ALPHA, a_gain);
			cfg_beat(REG_BETA, b_gain);
			if (p % 2 == 1)
				cfg_beat(REG_SPARE, 16'($urandom));
			cfg_bus.valid <= 1'b0;
			settings_run++;
			run_random(PHASE_BEATS);
		end

		wait_idle();
		$display("Run covered %0d item beats and %0d checked rows over %0d gain settings.",
			beats_sent, rows_checked, settings_run);
		$display("Gains reached both extremes; rows ran from one column up to 120 columns.");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, even with every gap and stall at its longest.
	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

endmodule
